// ===== rtl/wfs_pkg.sv =====
// Shared types and constants for the waveform statistics block.
package wfs_pkg;

	localparam int VALUE_W = 49;
	localparam logic [63:0] VMAX = 64'h0000_FFFF_FFFF_FFFF;
	localparam logic signed [32:0] MIN_START = 33'sh0_FFFF_FFFF;

	// One classified sample on its way from the front end to the accumulator.
	typedef struct packed {
		logic signed [15:0] x;
		logic [15:0]        mag;
		logic               eob;
		logic               drop;
	} smp_t;

	// Totals of one closed block handed to the result engine.
	typedef struct packed {
		logic signed [15:0] mx;
		logic signed [32:0] mn;
		logic [14:0]        n;
		logic signed [30:0] s1;
		logic [29:0]        sa;
		logic [44:0]        s2;
		logic signed [59:0] s3;
		logic [58:0]        s4;
		logic [29:0]        sr;
		logic               drop;
	} blk_t;

	typedef enum logic [3:0] {
		P_MAX, P_MIN, P_MEAN, P_AVG_ABS, P_RMS, P_SMRA, P_FORM,
		P_CREST_POS, P_CREST_NEG, P_IMPULSE_POS, P_IMPULSE_NEG,
		P_MARGIN_POS, P_MARGIN_NEG, P_KURTOSIS, P_SKEWNESS
	} param_t;

endpackage

// ===== rtl/wfs_front.sv =====
// Input stage: takes samples, sign-extends them and marks samples past capacity.
module wfs_front #(
	parameter int MAX_SAMPLES = 16384,
	parameter int SAMPLE_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [15:0]   s_tdata,   // [15:0] sample
	input  logic          s_tlast,
	output logic          push,
	output wfs_pkg::smp_t push_data,
	input  logic          full
);

	localparam int CW = $clog2(MAX_SAMPLES + 1);

	logic [CW-1:0]      cnt_q;
	logic               valid_s1;
	wfs_pkg::smp_t      item_s1;
	logic signed [15:0] x;
	logic               take;

	assign x         = 16'($signed(s_tdata[SAMPLE_BITS-1:0]));
	assign s_tready  = !valid_s1 || !full;
	assign take      = s_tvalid && s_tready;
	assign push      = valid_s1 && !full;
	assign push_data = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
			if (take) begin
				if (s_tlast) begin
					cnt_q <= '0;
				end else if (cnt_q < CW'(MAX_SAMPLES)) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.x    <= x;
			item_s1.mag  <= x[15] ? $unsigned(-x) : $unsigned(x);
			item_s1.eob  <= s_tlast;
			item_s1.drop <= cnt_q >= CW'(MAX_SAMPLES);
		end
	end

endmodule

// ===== rtl/wfs_fifo.sv =====
// Four-entry queue between the front end and the accumulator.
module wfs_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  wfs_pkg::smp_t push_data,
	output logic          full,
	input  logic          pop,
	output wfs_pkg::smp_t pop_data,
	output logic          empty
);

	localparam int DEPTH = 4;
	localparam int AW = $clog2(DEPTH);

	wfs_pkg::smp_t mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0]   cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full     = cnt_q == (AW+1)'(DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = mem_q[rd_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/wfs_accum.sv =====
// Accumulator: per-sample powers and root, running extremes and sums.
module wfs_accum (
	input  logic          clk,
	input  logic          arst_n,
	input  wfs_pkg::smp_t pop_data,
	input  logic          empty,
	output logic          pop,
	output wfs_pkg::blk_t blk,
	output logic          blk_valid,
	input  logic          blk_ready
);

	typedef enum logic [2:0] {
		A_IDLE, A_MUL1, A_MUL2, A_MUL3, A_ROOT, A_ADD, A_CLOSE
	} astate_t;

	astate_t            state_q;
	logic signed [15:0] mx_q;
	logic signed [32:0] mn_q;
	logic [14:0]        n_q;
	logic signed [30:0] s1_q;
	logic [29:0]        sa_q;
	logic [44:0]        s2_q;
	logic [59:0]        s3_q;
	logic [58:0]        s4_q;
	logic [29:0]        sr_q;
	logic               dropped_q;
	wfs_pkg::blk_t      done_q;
	logic               done_v_q;

	logic signed [15:0] x_q;
	logic [15:0]        mag_q;
	logic               eob_q;
	logic [31:0]        sq_q;
	logic [47:0]        cube_q;
	logic [47:0]        four_q;
	logic [31:0]        rv_q;
	logic [31:0]        rres_q;
	logic [31:0]        rbit_q;
	logic [63:0]        sq_sq;
	logic [59:0]        cube60;

	assign pop       = state_q == A_IDLE && !empty;
	assign blk       = done_q;
	assign blk_valid = done_v_q;
	assign sq_sq     = 64'(sq_q) * 64'(sq_q);
	assign cube60    = 60'(cube_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= A_IDLE;
			mx_q      <= '0;
			mn_q      <= wfs_pkg::MIN_START;
			n_q       <= '0;
			s1_q      <= '0;
			sa_q      <= '0;
			s2_q      <= '0;
			s3_q      <= '0;
			s4_q      <= '0;
			sr_q      <= '0;
			dropped_q <= 1'b0;
			done_q    <= '0;
			done_v_q  <= 1'b0;
		end else begin
			if (blk_valid && blk_ready) begin
				done_v_q <= 1'b0;
			end
			case (state_q)
				A_IDLE: begin
					if (!empty) begin
						if (pop_data.drop) begin
							dropped_q <= 1'b1;
							state_q   <= pop_data.eob ? A_CLOSE : A_IDLE;
						end else begin
							state_q <= A_MUL1;
						end
					end
				end
				A_MUL1: state_q <= A_MUL2;
				A_MUL2: state_q <= A_MUL3;
				A_MUL3: state_q <= A_ROOT;
				A_ROOT: begin
					if (rbit_q == '0) begin
						state_q <= A_ADD;
					end
				end
				A_ADD: begin
					if (x_q > mx_q) begin
						mx_q <= x_q;
					end
					if (33'(x_q) < mn_q) begin
						mn_q <= 33'(x_q);
					end
					n_q  <= n_q + 15'd1;
					s1_q <= s1_q + 31'(x_q);
					sa_q <= sa_q + 30'(mag_q);
					s2_q <= s2_q + 45'(sq_q);
					s3_q <= s3_q + (x_q[15] ? 60'(0) - cube60 : cube60);
					s4_q <= s4_q + 59'(four_q);
					sr_q <= sr_q + 30'(rres_q);
					state_q <= eob_q ? A_CLOSE : A_IDLE;
				end
				A_CLOSE: begin
					// hold the closed block until the result engine has taken the last one
					if (!done_v_q) begin
						done_q <= '{mx: mx_q, mn: mn_q, n: n_q, s1: s1_q, sa: sa_q, s2: s2_q,
							s3: $signed(s3_q), s4: s4_q, sr: sr_q, drop: dropped_q};
						done_v_q  <= 1'b1;
						mx_q      <= '0;
						mn_q      <= wfs_pkg::MIN_START;
						n_q       <= '0;
						s1_q      <= '0;
						sa_q      <= '0;
						s2_q      <= '0;
						s3_q      <= '0;
						s4_q      <= '0;
						sr_q      <= '0;
						dropped_q <= 1'b0;
						state_q   <= A_IDLE;
					end
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			x_q    <= pop_data.x;
			mag_q  <= pop_data.mag;
			eob_q  <= pop_data.eob;
			rv_q   <= {pop_data.mag, 16'h0000};
			rres_q <= '0;
			rbit_q <= 32'h4000_0000;
		end else if (rbit_q != '0) begin
			// one digit pair of the integer square root per cycle
			if (rv_q >= rres_q + rbit_q) begin
				rv_q   <= rv_q - (rres_q + rbit_q);
				rres_q <= (rres_q >> 1) + rbit_q;
			end else begin
				rres_q <= rres_q >> 1;
			end
			rbit_q <= rbit_q >> 2;
		end
		if (state_q == A_MUL1) begin
			sq_q <= 32'(mag_q) * 32'(mag_q);
		end
		if (state_q == A_MUL2) begin
			cube_q <= 48'(sq_q) * 48'(mag_q);
		end
		if (state_q == A_MUL3) begin
			four_q <= sq_sq[63:16];
		end
	end

endmodule

// ===== rtl/wfs_final.sv =====
// Result engine: shared divider, multiplier and square root sequenced over fifteen results.
module wfs_final (
	input  logic          clk,
	input  logic          arst_n,
	input  wfs_pkg::blk_t blk,
	input  logic          blk_valid,
	output logic          blk_ready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [55:0]   m_tdata,
	output logic [5:0]    m_tuser,
	output logic          m_tlast
);

	typedef enum logic [1:0] {F_IDLE, F_PLAN, F_RUN} fstate_t;
	typedef enum logic [1:0] {OP_DIV, OP_MUL, OP_ROOT} op_t;
	typedef enum logic [1:0] {PL_EMIT, PL_DIV, PL_MUL, PL_ROOT} plkind_t;

	typedef struct packed {
		plkind_t            kind;
		logic [127:0]       a;
		logic [127:0]       b;
		logic               neg;
		logic signed [48:0] value;
		logic               zd;
	} plan_t;

	fstate_t          state_q;
	op_t              op_q;
	wfs_pkg::param_t  idx_q;
	logic [2:0]       sub_q;
	logic             out_v_q;
	logic [48:0]      out_val_q;
	wfs_pkg::param_t  out_idx_q;
	logic             out_zd_q;
	logic             out_ovf_q;
	logic             out_last_q;

	wfs_pkg::blk_t    b_q;
	logic [63:0]      avg_q;
	logic [63:0]      rms_q;
	logic [63:0]      smra_q;
	logic [127:0]     t_q;
	logic             neg_q;
	logic             dz_q;
	logic [128:0]     rem_q;
	logic [127:0]     num_q;
	logic [127:0]     den_q;
	logic [63:0]      quo_q;
	logic             sat_q;
	logic [6:0]       cnt_q;
	logic [127:0]     ma_q;
	logic [63:0]      mb_q;
	logic [127:0]     macc_q;
	logic [63:0]      rv_q;
	logic [63:0]      rres_q;
	logic [63:0]      rbit_q;

	plan_t              pl;
	logic [63:0]        qc;
	logic signed [48:0] rat;
	logic [127:0]       n_w;
	logic [30:0]        s1_mag;
	logic [32:0]        mn_mag;
	logic [59:0]        s3_mag;
	logic [63:0]        ms;
	logic [63:0]        rdn;
	logic               emit_go;
	logic               unit_done;
	logic [128:0]       rem_n;
	logic               ge;

	assign blk_ready = state_q == F_IDLE;
	assign m_tvalid  = out_v_q;
	assign m_tdata   = {7'b0, out_val_q};
	assign m_tuser   = {out_ovf_q, out_zd_q, out_idx_q};
	assign m_tlast   = out_last_q;

	assign qc     = (sat_q || quo_q > wfs_pkg::VMAX) ? wfs_pkg::VMAX : quo_q;
	assign rat    = dz_q ? '0 : (neg_q ? 49'(0) - 49'(qc) : 49'(qc));
	assign n_w    = 128'(b_q.n);
	assign s1_mag = b_q.s1[30] ? $unsigned(-b_q.s1) : $unsigned(b_q.s1);
	assign mn_mag = b_q.mn[32] ? $unsigned(-b_q.mn) : $unsigned(b_q.mn);
	assign s3_mag = b_q.s3[59] ? $unsigned(-b_q.s3) : $unsigned(b_q.s3);
	assign ms     = dz_q ? '0 : quo_q;
	assign rem_n  = {rem_q[127:0], num_q[127]};
	assign ge     = rem_n >= {1'b0, den_q};

	always_comb begin
		case (idx_q)
			wfs_pkg::P_CREST_POS, wfs_pkg::P_CREST_NEG:     rdn = rms_q;
			wfs_pkg::P_IMPULSE_POS, wfs_pkg::P_IMPULSE_NEG: rdn = avg_q;
			default:                                        rdn = smra_q;
		endcase
	end

	// Pick the next micro-operation of the current result from its index and step.
	always_comb begin
		pl = '{kind: PL_EMIT, a: '0, b: '0, neg: 1'b0, value: '0, zd: 1'b0};
		case (idx_q)
			wfs_pkg::P_MAX: pl.value = 49'(b_q.mx) << 16;
			wfs_pkg::P_MIN: pl.value = 49'(b_q.mn) << 16;
			wfs_pkg::P_MEAN, wfs_pkg::P_AVG_ABS: begin
				if (sub_q == 3'd0) begin
					pl.kind = PL_DIV;
					pl.a    = (idx_q == wfs_pkg::P_MEAN ? 128'(s1_mag) : 128'(b_q.sa)) << 16;
					pl.b    = n_w;
					pl.neg  = idx_q == wfs_pkg::P_MEAN && b_q.s1[30];
				end else begin
					pl.value = rat;
					pl.zd    = dz_q;
				end
			end
			wfs_pkg::P_RMS: begin
				if (sub_q == 3'd0) begin
					pl.kind = PL_DIV;
					pl.a    = 128'(b_q.s2) << 32;
					pl.b    = n_w;
				end else if (sub_q == 3'd1) begin
					pl.kind = PL_ROOT;
					pl.a    = 128'(ms);
				end else begin
					pl.value = 49'(rres_q);
					pl.zd    = b_q.n == '0;
				end
			end
			wfs_pkg::P_SMRA: begin
				if (sub_q == 3'd0) begin
					pl.kind = PL_DIV;
					pl.a    = 128'(b_q.sr) << 8;
					pl.b    = n_w;
				end else if (sub_q == 3'd1) begin
					pl.kind = PL_MUL;
					pl.a    = 128'(ms);
					pl.b    = 128'(ms);
				end else begin
					pl.value = 49'(macc_q >> 16);
					pl.zd    = b_q.n == '0;
				end
			end
			wfs_pkg::P_FORM: begin
				if (sub_q == 3'd0) begin
					pl.kind = PL_DIV;
					pl.a    = 128'(rms_q) << 16;
					pl.b    = 128'(avg_q);
				end else begin
					pl.value = rat;
					pl.zd    = dz_q;
				end
			end
			wfs_pkg::P_CREST_POS, wfs_pkg::P_IMPULSE_POS, wfs_pkg::P_MARGIN_POS: begin
				if (sub_q == 3'd0) begin
					pl.kind = PL_DIV;
					pl.a    = 128'($unsigned(b_q.mx)) << 32;
					pl.b    = 128'(rdn);
				end else begin
					pl.value = rat;
					pl.zd    = dz_q;
				end
			end
			wfs_pkg::P_CREST_NEG, wfs_pkg::P_IMPULSE_NEG, wfs_pkg::P_MARGIN_NEG: begin
				if (sub_q == 3'd0) begin
					pl.kind = PL_DIV;
					pl.a    = 128'(mn_mag) << 32;
					pl.b    = 128'(rdn);
					pl.neg  = b_q.mn[32];
				end else begin
					pl.value = rat;
					pl.zd    = dz_q;
				end
			end
			wfs_pkg::P_KURTOSIS: begin
				case (sub_q)
					3'd0: begin
						pl.kind = PL_MUL;
						pl.a    = 128'(b_q.s2);
						pl.b    = 128'(b_q.s2);
					end
					3'd1: begin
						pl.kind = PL_MUL;
						pl.a    = 128'(b_q.s4);
						pl.b    = n_w;
					end
					3'd2: begin
						pl.kind = PL_DIV;
						pl.a    = macc_q << 32;
						pl.b    = t_q;
					end
					default: begin
						pl.value = rat;
						pl.zd    = dz_q;
					end
				endcase
			end
			wfs_pkg::P_SKEWNESS: begin
				case (sub_q)
					3'd0: begin
						pl.kind = PL_MUL;
						pl.a    = 128'(rms_q);
						pl.b    = 128'(rms_q);
					end
					3'd1: begin
						pl.kind = PL_MUL;
						pl.a    = macc_q;
						pl.b    = 128'(rms_q);
					end
					3'd2: begin
						pl.kind = PL_MUL;
						pl.a    = macc_q;
						pl.b    = n_w;
					end
					3'd3: begin
						pl.kind = PL_DIV;
						pl.a    = 128'(s3_mag) << 64;
						pl.b    = macc_q;
						pl.neg  = b_q.s3[59];
					end
					default: begin
						pl.value = rat;
						pl.zd    = dz_q;
					end
				endcase
			end
			default: pl.value = '0;
		endcase
	end

	assign emit_go = state_q == F_PLAN && pl.kind == PL_EMIT && (!out_v_q || m_tready);

	always_comb begin
		case (op_q)
			OP_DIV:  unit_done = cnt_q == '0;
			OP_MUL:  unit_done = mb_q == '0;
			OP_ROOT: unit_done = rbit_q == '0;
			default: unit_done = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= F_IDLE;
			op_q       <= OP_DIV;
			idx_q      <= wfs_pkg::P_MAX;
			sub_q      <= '0;
			out_v_q    <= 1'b0;
			out_val_q  <= '0;
			out_idx_q  <= wfs_pkg::P_MAX;
			out_zd_q   <= 1'b0;
			out_ovf_q  <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			if (m_tready && !emit_go) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				F_IDLE: begin
					if (blk_valid) begin
						state_q <= F_PLAN;
						idx_q   <= wfs_pkg::P_MAX;
						sub_q   <= '0;
					end
				end
				F_PLAN: begin
					case (pl.kind)
						PL_EMIT: begin
							if (emit_go) begin
								out_v_q    <= 1'b1;
								out_val_q  <= $unsigned(pl.value);
								out_idx_q  <= idx_q;
								out_zd_q   <= pl.zd;
								out_ovf_q  <= b_q.drop;
								out_last_q <= idx_q == wfs_pkg::P_SKEWNESS;
								sub_q      <= '0;
								if (idx_q == wfs_pkg::P_SKEWNESS) begin
									state_q <= F_IDLE;
								end else begin
									idx_q <= wfs_pkg::param_t'(idx_q + 4'd1);
								end
							end
						end
						PL_DIV: begin
							// a zero divisor skips the division and flags the result
							if (pl.b == '0) begin
								sub_q <= sub_q + 3'd1;
							end else begin
								op_q    <= OP_DIV;
								state_q <= F_RUN;
							end
						end
						PL_MUL: begin
							op_q    <= OP_MUL;
							state_q <= F_RUN;
						end
						PL_ROOT: begin
							op_q    <= OP_ROOT;
							state_q <= F_RUN;
						end
						default: state_q <= F_IDLE;
					endcase
				end
				F_RUN: begin
					if (unit_done) begin
						state_q <= F_PLAN;
						sub_q   <= sub_q + 3'd1;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && blk_valid) begin
			b_q <= blk;
		end
		if (state_q == F_PLAN) begin
			case (pl.kind)
				PL_DIV: begin
					neg_q <= pl.neg;
					dz_q  <= pl.b == '0;
					num_q <= pl.a;
					den_q <= pl.b;
					rem_q <= '0;
					quo_q <= '0;
					sat_q <= 1'b0;
					cnt_q <= 7'd127;
				end
				PL_MUL: begin
					ma_q   <= pl.a;
					mb_q   <= pl.b[63:0];
					macc_q <= '0;
				end
				PL_ROOT: begin
					rv_q   <= pl.a[63:0];
					rres_q <= '0;
					rbit_q <= 64'h4000_0000_0000_0000;
				end
				PL_EMIT: begin
					if (emit_go && idx_q == wfs_pkg::P_AVG_ABS) begin
						avg_q <= 64'($unsigned(rat));
					end
					if (emit_go && idx_q == wfs_pkg::P_RMS) begin
						rms_q <= rres_q;
					end
					if (emit_go && idx_q == wfs_pkg::P_SMRA) begin
						smra_q <= 64'(macc_q >> 16);
					end
				end
				default: ;
			endcase
			if (idx_q == wfs_pkg::P_KURTOSIS && sub_q == 3'd1) begin
				t_q <= macc_q;
			end
		end
		if (state_q == F_RUN) begin
			case (op_q)
				OP_DIV: begin
					// restoring division, one quotient bit per cycle from the top
					rem_q <= ge ? rem_n - {1'b0, den_q} : rem_n;
					num_q <= num_q << 1;
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q[6]) begin
						sat_q <= sat_q || ge;
					end else begin
						quo_q <= {quo_q[62:0], ge};
					end
				end
				OP_MUL: begin
					if (mb_q != '0) begin
						if (mb_q[0]) begin
							macc_q <= macc_q + ma_q;
						end
						ma_q <= ma_q << 1;
						mb_q <= mb_q >> 1;
					end
				end
				OP_ROOT: begin
					if (rbit_q != '0) begin
						if (rv_q >= rres_q + rbit_q) begin
							rv_q   <= rv_q - (rres_q + rbit_q);
							rres_q <= (rres_q >> 1) + rbit_q;
						end else begin
							rres_q <= rres_q >> 1;
						end
						rbit_q <= rbit_q >> 2;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/waveform_statistics.sv =====
// Top level of the waveform statistics block.
// Time-domain vibration features over blocks of signed samples.
// Input stream: s_tdata carries one sample, s_tlast marks the last sample of a
// block. Samples beyond MAX_SAMPLES in one block are dropped and reported
// through the overflow flag; a dropped sample with s_tlast still closes the block.
// Output stream: fifteen results per block in index order, m_tlast on the last.
// Value is signed fixed point with 16 fraction bits; a zero divisor gives 0 and
// sets the zero_divisor flag.
// The accumulator finishes each sample, with its 16-step square root of |x|
// and three multiplies, before it takes the next; a four-entry queue lets the
// input side run ahead. The result engine closes a block with its 128-step
// divider (thirteen divisions), the shift-add multiplier and the 32-step square
// root and takes a new block only when done; the next block accumulates meanwhile.
// Reset clears all totals to their start values (minimum 4294967295).
// When the receiver stalls, the result engine holds; the accumulator keeps one
// closed block waiting and then back-pressures the input.
module waveform_statistics #(
	parameter int MAX_SAMPLES = 16384,
	parameter int SAMPLE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] sample
	input  logic        s_tlast,   // end_of_block
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [48:0] value, [55:49] zero
	output logic [5:0]  m_tuser,   // [3:0] param_index, [4] zero_divisor, [5] overflow
	output logic        m_tlast    // last_result
);

	logic          push;
	wfs_pkg::smp_t push_data;
	logic          full;
	logic          pop;
	wfs_pkg::smp_t pop_data;
	logic          empty;
	wfs_pkg::blk_t blk;
	logic          blk_valid;
	logic          blk_ready;

	wfs_front #(
		.MAX_SAMPLES(MAX_SAMPLES),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.push(push), .push_data(push_data), .full(full)
	);

	wfs_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_data(push_data), .full(full),
		.pop(pop), .pop_data(pop_data), .empty(empty)
	);

	wfs_accum u_accum (
		.clk(clk), .arst_n(arst_n),
		.pop_data(pop_data), .empty(empty), .pop(pop),
		.blk(blk), .blk_valid(blk_valid), .blk_ready(blk_ready)
	);

	wfs_final u_final (
		.clk(clk), .arst_n(arst_n),
		.blk(blk), .blk_valid(blk_valid), .blk_ready(blk_ready),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

endmodule

// ===== rtl/wfs_checker.sv =====
// Port-level checks for the waveform statistics block, bound to the top level.
module wfs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic [5:0]  m_tuser,
	input logic        m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[3:0] == wfs_pkg::P_SKEWNESS)
		else $error("last flag on wrong index");

	a_zd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[4] |-> m_tdata[48:0] == 49'd0)
		else $error("zero divisor with nonzero value");

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=>
		!(m_tvalid && m_tuser[3:0] == wfs_pkg::P_MAX))
		else $error("block restarted before its last result");

	a_extreme_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[3:0] == wfs_pkg::P_MAX || m_tuser[3:0] == wfs_pkg::P_MIN)
		|-> !m_tuser[4])
		else $error("zero divisor on max or min");

endmodule

bind waveform_statistics wfs_checker u_wfs_checker (.*);
